// ----- hdl/vqdm_pkg.sv -----
// Shared types, codes and helpers for the virtqueue descriptor manager.
// Holds the input/result payload structs and the controller-to-datapath command.
// No dependencies.
`default_nettype none

package vqdm_pkg;

	// Descriptor index span that the field widths can address
	localparam int DESC_IDX_W    = 8;
	localparam int IDX_SPAN      = 1 << DESC_IDX_W;
	localparam int MAX_QUEUE_DEF = 256;
	localparam int CFG_W         = 9;

	localparam logic [15:0] FLAG_NEXT = 16'h0001;

	// Function codes
	localparam logic [1:0] FUNC_ADD     = 2'd0;
	localparam logic [1:0] FUNC_COLLECT = 2'd1;
	localparam logic [1:0] FUNC_READ    = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] buf_addr;
		logic [31:0] buf_len;
		logic [15:0] buf_flags;
		logic [31:0] tag;
		logic [15:0] device_used_idx;
		logic [7:0]  used_id;
		logic [31:0] used_len;
		logic [7:0]  read_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  desc_index;
		logic [7:0]  ring_slot;
		logic [15:0] avail_count;
		logic [31:0] tag_out;
		logic [31:0] done_len;
		logic [63:0] entry_addr;
		logic [31:0] entry_len;
		logic [15:0] entry_flags;
		logic [7:0]  entry_next;
		logic [8:0]  free_count;
	} out_item_t;

	typedef struct packed {
		logic capture;  // input transfer: latch operands, read the table
		logic commit;   // execute: update table and pointers, load result
		logic cfg_wr;   // queue size write: rebuild the queue
	} dp_cmd_t;

	// Largest power of two not above v and not above cap_v; one when either is zero
	function automatic logic [8:0] legal_size(input logic [8:0] v, input logic [8:0] cap_v);
		logic [8:0] lim;
		logic [8:0] p;
		lim = (v > cap_v) ? cap_v : v;
		p = 9'd1;
		for (int b = 0; b < 9; b++) begin
			if (lim[b]) begin
				p = 9'd1 << b;
			end
		end
		return p;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/vqdm_ctrl.sv -----
// Controller for the virtqueue descriptor manager: idle/execute sequencing,
// handshakes and result-valid register. Depends on vqdm_pkg.
`default_nettype none

module vqdm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	output vqdm_pkg::dp_cmd_t     cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   commit;

	always_comb begin
		cfg_ready   = (state_q == ST_IDLE);
		// a config write takes the idle cycle first
		in_ready    = (state_q == ST_IDLE) && !cfg_valid;
		commit      = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
		cmd.capture = in_valid && in_ready;
		cmd.commit  = commit;
		cmd.cfg_wr  = cfg_valid && cfg_ready;
		out_valid   = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (in_valid && in_ready) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// hold until the result register is free
					if (commit) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/vqdm_dp.sv -----
// Datapath for the virtqueue descriptor manager: descriptor table memories,
// free list and ring pointers, result register. Depends on vqdm_pkg.
`default_nettype none

module vqdm_dp #(
	parameter int MAX_QUEUE = vqdm_pkg::MAX_QUEUE_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire vqdm_pkg::dp_cmd_t               cmd,
	input  wire vqdm_pkg::in_item_t              in_data,
	input  wire logic [vqdm_pkg::CFG_W-1:0]      cfg_data,
	output vqdm_pkg::out_item_t                  out_data
);

	localparam int CAP   = (MAX_QUEUE < vqdm_pkg::IDX_SPAN) ? MAX_QUEUE : vqdm_pkg::IDX_SPAN;
	localparam int AW    = $clog2(CAP + 1) - 1;
	localparam int DEPTH = 1 << AW;

	// Descriptor table
	logic [63:0]   addr_mem  [DEPTH];
	logic [31:0]   len_mem   [DEPTH];
	logic [15:0]   flags_mem [DEPTH];
	logic [AW-1:0] next_mem  [DEPTH];
	logic [31:0]   tag_mem   [DEPTH];

	// Entry written by an add or a collect since the last rebuild
	logic [DEPTH-1:0] full_vld_q;

	logic [AW:0]   size_q;
	logic [AW-1:0] mask_q;
	logic [AW-1:0] head_q;
	logic [AW:0]   count_q;
	logic [15:0]   avail_q;
	logic [15:0]   last_q;

	// Operands latched at the input transfer
	logic [1:0]    func_s1;
	logic [63:0]   buf_addr_s1;
	logic [31:0]   buf_len_s1;
	logic [15:0]   buf_flags_s1;
	logic [31:0]   tag_s1;
	logic [15:0]   dev_idx_s1;
	logic [31:0]   used_len_s1;
	logic [AW-1:0] addr_s1;

	// Table read data
	logic [63:0]   addr_rd_s1;
	logic [31:0]   len_rd_s1;
	logic [15:0]   flags_rd_s1;
	logic [AW-1:0] next_rd_s1;
	logic [31:0]   tag_rd_s1;

	vqdm_pkg::out_item_t out_q;
	vqdm_pkg::out_item_t res;

	logic [AW-1:0] rd_addr;
	logic [63:0]   addr_v;
	logic [31:0]   len_v;
	logic [15:0]   flags_v;
	logic [AW-1:0] next_v;
	logic [31:0]   tag_v;
	logic [AW-1:0] nxt_head;
	logic [AW:0]   nxt_count;
	logic [15:0]   nxt_avail;
	logic [15:0]   nxt_last;
	logic          add_ok;
	logic          coll_ok;
	logic          wr_add;
	logic          wr_coll;
	logic [8:0]    new_size;
	logic          rebuild;

	assign out_data = out_q;

	always_comb begin
		unique case (in_data.func)
			vqdm_pkg::FUNC_COLLECT: rd_addr = in_data.used_id[AW-1:0] & mask_q;
			vqdm_pkg::FUNC_READ:    rd_addr = in_data.read_index[AW-1:0] & mask_q;
			default:                rd_addr = head_q;
		endcase
	end

	// Unwritten entries read as the rebuilt table
	always_comb begin
		addr_v  = full_vld_q[addr_s1] ? addr_rd_s1 : 64'd0;
		len_v   = full_vld_q[addr_s1] ? len_rd_s1  : 32'd0;
		tag_v   = full_vld_q[addr_s1] ? tag_rd_s1  : 32'd0;
		flags_v = full_vld_q[addr_s1] ? flags_rd_s1 :
		          ((addr_s1 == mask_q) ? 16'd0 : vqdm_pkg::FLAG_NEXT);
		next_v  = full_vld_q[addr_s1] ? next_rd_s1 : ((addr_s1 + AW'(1)) & mask_q);
	end

	always_comb begin
		res       = '0;
		res.status = vqdm_pkg::ST_OK;
		nxt_head  = head_q;
		nxt_count = count_q;
		nxt_avail = avail_q;
		nxt_last  = last_q;
		add_ok    = 1'b0;
		coll_ok   = 1'b0;
		unique case (func_s1)
			vqdm_pkg::FUNC_ADD: begin
				if (count_q == '0) begin
					res.status = vqdm_pkg::ST_FULL;
				end else begin
					add_ok         = 1'b1;
					res.desc_index = 8'(addr_s1);
					res.ring_slot  = 8'(avail_q[AW-1:0] & mask_q);
					nxt_head       = next_v & mask_q;
					nxt_count      = count_q - 1'b1;
					nxt_avail      = avail_q + 16'd1;
				end
			end
			vqdm_pkg::FUNC_COLLECT: begin
				if (dev_idx_s1 == last_q) begin
					res.status = vqdm_pkg::ST_EMPTY;
				end else begin
					coll_ok        = 1'b1;
					res.desc_index = 8'(addr_s1);
					res.ring_slot  = 8'(last_q[AW-1:0] & mask_q);
					res.tag_out    = tag_v;
					res.done_len   = used_len_s1;
					nxt_head       = addr_s1;
					if (count_q < size_q) begin
						nxt_count = count_q + 1'b1;
					end
					nxt_last = last_q + 16'd1;
				end
			end
			vqdm_pkg::FUNC_READ: begin
				res.desc_index  = 8'(addr_s1);
				res.entry_addr  = addr_v;
				res.entry_len   = len_v;
				res.entry_flags = flags_v;
				res.entry_next  = 8'(next_v);
			end
			default: begin
			end
		endcase
		res.avail_count = nxt_avail;
		res.free_count  = 9'(nxt_count);
		wr_add  = cmd.commit && add_ok;
		wr_coll = cmd.commit && coll_ok;
	end

	always_comb begin
		new_size = vqdm_pkg::legal_size(cfg_data, 9'(DEPTH));
		rebuild  = cmd.cfg_wr && (cfg_data != '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_s1      <= in_data.func;
			buf_addr_s1  <= in_data.buf_addr;
			buf_len_s1   <= in_data.buf_len;
			buf_flags_s1 <= in_data.buf_flags;
			tag_s1       <= in_data.tag;
			dev_idx_s1   <= in_data.device_used_idx;
			used_len_s1  <= in_data.used_len;
			addr_s1      <= rd_addr;
		end
		if (cmd.commit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_rd_s1  <= addr_mem[rd_addr];
			len_rd_s1   <= len_mem[rd_addr];
			flags_rd_s1 <= flags_mem[rd_addr];
			next_rd_s1  <= next_mem[rd_addr];
			tag_rd_s1   <= tag_mem[rd_addr];
		end
		if (wr_add) begin
			addr_mem[addr_s1]  <= buf_addr_s1;
			len_mem[addr_s1]   <= buf_len_s1;
			flags_mem[addr_s1] <= buf_flags_s1;
			next_mem[addr_s1]  <= '0;
			tag_mem[addr_s1]   <= tag_s1;
		end
		if (wr_coll) begin
			// write back the current address, length and flags with the new link; clear the tag
			addr_mem[addr_s1]  <= addr_v;
			len_mem[addr_s1]   <= len_v;
			flags_mem[addr_s1] <= flags_v;
			next_mem[addr_s1]  <= head_q;
			tag_mem[addr_s1]   <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q     <= (AW + 1)'(DEPTH);
			mask_q     <= AW'(DEPTH - 1);
			head_q     <= '0;
			count_q    <= (AW + 1)'(DEPTH);
			avail_q    <= '0;
			last_q     <= '0;
			full_vld_q <= '0;
		end else if (rebuild) begin
			size_q     <= new_size[AW:0];
			mask_q     <= AW'(new_size - 9'd1);
			head_q     <= '0;
			count_q    <= new_size[AW:0];
			avail_q    <= '0;
			last_q     <= '0;
			full_vld_q <= '0;
		end else if (cmd.commit) begin
			head_q  <= nxt_head;
			count_q <= nxt_count;
			avail_q <= nxt_avail;
			last_q  <= nxt_last;
			if (wr_add || wr_coll) begin
				full_vld_q[addr_s1] <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/virtqueue_descriptor_manager.sv -----
// The input transfer latches the operands and reads the table; the result register loads
//   when the execute state commits, and the result can transfer after that.
// A new item is accepted only after the previous one commits: the free-head update waits
//   on the next link read from the registered descriptor table port for the next add.
// A result stalled by out_ready holds the next item in execute until it transfers.
// Reset: pointers reset to an empty queue of full size; table entries read their rebuilt
//   values through per-entry valid flags that reset and queue size writes clear at once.
`default_nettype none

// Top level of the virtqueue descriptor manager: controller plus datapath.
// Depends on vqdm_pkg, vqdm_ctrl and vqdm_dp.
module virtqueue_descriptor_manager #(
	parameter int MAX_QUEUE = vqdm_pkg::MAX_QUEUE_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// operation channel
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire vqdm_pkg::in_item_t         in_data,
	// result channel
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output vqdm_pkg::out_item_t             out_data,
	// queue size register write channel
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [vqdm_pkg::CFG_W-1:0] cfg_data
);

	// Command bundle from the sequencer into the datapath:
	// capture latches operands and issues the table read,
	// commit writes back the table, advances pointers and loads the result,
	// cfg_wr rebuilds the queue.
	vqdm_pkg::dp_cmd_t cmd;

	// Sequencer: one item in flight; a finished result waits in the
	// result register while the next item is accepted.
	vqdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	// Datapath: descriptor table memories, free list head and count,
	// available and last-used indices, result register.
	vqdm_dp #(
		.MAX_QUEUE (MAX_QUEUE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.cfg_data (cfg_data),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

// ----- hdl/vqdm_checker.sv -----
// Port-level checks for the virtqueue descriptor manager, bound to the top level.
// Depends on vqdm_pkg.
`default_nettype none

module vqdm_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire vqdm_pkg::out_item_t        out_data,
	input wire logic                       cfg_valid,
	input wire logic                       cfg_ready
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// One item at a time: no transfer in the cycle after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !cfg_ready)
		else $error("accepted while an item is in flight");

	// Config write and input transfer never coincide
	a_cfg_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !(in_valid && in_ready))
		else $error("config write and input transfer in one cycle");

	// A refused operation reports nothing but the counters
	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != vqdm_pkg::ST_OK |->
			out_data.desc_index == 8'd0 && out_data.tag_out == 32'd0 &&
			out_data.entry_addr == 64'd0)
		else $error("refused operation carries data");

	// Free count never exceeds the table span
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.free_count <= 9'(vqdm_pkg::IDX_SPAN))
		else $error("free count out of range");

endmodule

bind virtqueue_descriptor_manager vqdm_checker u_vqdm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

`default_nettype wire

// ----- test/tb_virtqueue_descriptor_manager.sv -----
// Self-checking testbench for the virtqueue descriptor manager: predicts each result
// from its own copy of the descriptor table, free list and ring indices.
// Depends on vqdm_pkg and virtqueue_descriptor_manager.

module tb_virtqueue_descriptor_manager;
	timeunit 1ns;
	timeprecision 1ps;

	// func 3 has no package code; the block treats it as a no-op
	localparam logic [1:0] FUNC_NOP = 2'd3;

	localparam int unsigned CYCLE_LIMIT    = 100_000;
	localparam int unsigned PHASE_OPS      = 66;
	localparam int unsigned TAIL_OPS       = 60;
	localparam int unsigned PAIR_OPS       = 12;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

	// Descriptor ring tracker: mirrors the table, free list and indices, and
	// holds the results still owed by the block in transfer order.
	class desc_ring_tracker;
		logic [63:0] addr_mem  [vqdm_pkg::IDX_SPAN];
		logic [31:0] len_mem   [vqdm_pkg::IDX_SPAN];
		logic [15:0] flags_mem [vqdm_pkg::IDX_SPAN];
		logic [7:0]  next_mem  [vqdm_pkg::IDX_SPAN];
		logic [31:0] tag_mem   [vqdm_pkg::IDX_SPAN];
		int unsigned qsize;
		logic [7:0]  mask;
		logic [7:0]  head;
		int unsigned nfree;
		logic [15:0] avail_idx;
		logic [15:0] used_idx;
		vqdm_pkg::out_item_t due_results [$];
		logic [7:0]  in_flight [$];
		int unsigned errors;

		function new();
			errors = 0;
			rebuild(vqdm_pkg::MAX_QUEUE_DEF);
		endfunction

		function void rebuild(int unsigned size);
			qsize = size;
			mask = 8'(size - 1);
			for (int i = 0; i < vqdm_pkg::IDX_SPAN; i++) begin
				addr_mem[i] = '0;
				len_mem[i] = '0;
				tag_mem[i] = '0;
				flags_mem[i] = (i + 1 < size) ? vqdm_pkg::FLAG_NEXT : 16'h0;
				next_mem[i] = (i + 1 < size) ? 8'(i + 1) : 8'h0;
			end
			head = '0;
			nfree = size;
			avail_idx = '0;
			used_idx = '0;
			in_flight.delete();
		endfunction

		// Zero is dropped; anything else rounds down to a power of two within the cap.
		function void write_size(logic [8:0] v);
			int unsigned p;
			p = 1;
			if (v == 0)
				return;
			while (p * 2 <= v && p * 2 <= 256 && p * 2 <= vqdm_pkg::MAX_QUEUE_DEF)
				p = p * 2;
			rebuild(p);
		endfunction

		function void retire(logic [7:0] d);
			int hits [$];
			hits = in_flight.find_first_index(x) with (x == d);
			if (hits.size() != 0)
				in_flight.delete(hits[0]);
		endfunction

		function void apply_op(vqdm_pkg::in_item_t op);
			vqdm_pkg::out_item_t r;
			logic [7:0] d;
			r = '0;
			r.status = vqdm_pkg::ST_OK;
			case (op.func)
			vqdm_pkg::FUNC_ADD: begin
				if (nfree == 0) begin
					r.status = vqdm_pkg::ST_FULL;
				end else begin
					d = head & mask;
					head = next_mem[d] & mask;
					nfree--;
					addr_mem[d] = op.buf_addr;
					len_mem[d] = op.buf_len;
					flags_mem[d] = op.buf_flags;
					next_mem[d] = 8'h0;
					tag_mem[d] = op.tag;
					r.desc_index = d;
					r.ring_slot = avail_idx[7:0] & mask;
					avail_idx++;
					in_flight.push_back(d);
				end
			end
			vqdm_pkg::FUNC_COLLECT: begin
				if (op.device_used_idx == used_idx) begin
					r.status = vqdm_pkg::ST_EMPTY;
				end else begin
					d = op.used_id & mask;
					r.desc_index = d;
					r.ring_slot = used_idx[7:0] & mask;
					r.tag_out = tag_mem[d];
					r.done_len = op.used_len;
					tag_mem[d] = '0;
					// relink even when the descriptor was never handed out
					next_mem[d] = head & mask;
					head = d;
					if (nfree < qsize)
						nfree++;
					used_idx++;
					retire(d);
				end
			end
			vqdm_pkg::FUNC_READ: begin
				d = op.read_index & mask;
				r.desc_index = d;
				r.entry_addr = addr_mem[d];
				r.entry_len = len_mem[d];
				r.entry_flags = flags_mem[d];
				r.entry_next = next_mem[d];
			end
			default: begin
			end
			endcase
			r.avail_count = avail_idx;
			r.free_count = 9'(nfree);
			due_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_result(vqdm_pkg::out_item_t got);
			vqdm_pkg::out_item_t want;
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual %h", $time, got);
				return;
			end
			want = due_results.pop_front();
			compare_field("status", 64'(want.status), 64'(got.status));
			compare_field("desc_index", 64'(want.desc_index), 64'(got.desc_index));
			compare_field("ring_slot", 64'(want.ring_slot), 64'(got.ring_slot));
			compare_field("avail_count", 64'(want.avail_count), 64'(got.avail_count));
			compare_field("tag_out", 64'(want.tag_out), 64'(got.tag_out));
			compare_field("done_len", 64'(want.done_len), 64'(got.done_len));
			compare_field("entry_addr", want.entry_addr, got.entry_addr);
			compare_field("entry_len", 64'(want.entry_len), 64'(got.entry_len));
			compare_field("entry_flags", 64'(want.entry_flags), 64'(got.entry_flags));
			compare_field("entry_next", 64'(want.entry_next), 64'(got.entry_next));
			compare_field("free_count", 64'(want.free_count), 64'(got.free_count));
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	vqdm_pkg::in_item_t            in_data = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	vqdm_pkg::out_item_t           out_data;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [vqdm_pkg::CFG_W-1:0]    cfg_data = '0;

	int unsigned          send_idle_pct = 0;
	int unsigned          recv_stall_pct = 0;

	desc_ring_tracker     ring = new();

	virtqueue_descriptor_manager uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial forever #6 clk = ~clk;

	// Draw the receiver's ready fresh every cycle; the stall rate follows the phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Sample both channels at the falling edge, clear of the driving edge.
	// Check the result first: a result leaving on the same edge as a new input
	// belongs to an older operation.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				ring.check_result(out_data);
			if (in_valid && in_ready)
				ring.apply_op(in_data);
		end
	end

	// Hard stop for a hung handshake.
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("virtqueue_descriptor_manager regression: fail");
		$finish;
	end

	function automatic void set_idle(idle_mode_e mode);
		case (mode)
		IDLE_NONE: begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
		IDLE_SEND: begin
			send_idle_pct = 84;
			recv_stall_pct = 0;
		end
		IDLE_RECV: begin
			send_idle_pct = 0;
			recv_stall_pct = 84;
		end
		default: begin
			send_idle_pct = 11;
			recv_stall_pct = 11;
		end
		endcase
	endfunction

	// Build one random operation. Most collects name a descriptor that is really
	// outstanding and advance the device index past the last-used one; the rest
	// find nothing used or hand back a descriptor that was never taken.
	function automatic vqdm_pkg::in_item_t make_op();
		vqdm_pkg::in_item_t op;
		int unsigned n;
		int unsigned roll;
		logic [7:0] hi;
		op.func = FUNC_NOP;
		op.buf_addr = {$urandom, $urandom};
		op.buf_len = $urandom;
		op.buf_flags = 16'($urandom);
		op.tag = $urandom;
		op.device_used_idx = 16'($urandom);
		op.used_id = 8'($urandom);
		op.used_len = $urandom;
		op.read_index = 8'($urandom);
		n = ring.in_flight.size();
		// bits above the queue mask must be dropped by the block
		hi = 8'($urandom) & ~ring.mask;
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			op.func = FUNC_NOP;
		end else if (roll < 25) begin
			op.func = vqdm_pkg::FUNC_READ;
			if (n != 0 && $urandom_range(0, 1) != 0)
				op.read_index = ring.in_flight[$urandom_range(0, n - 1)] | hi;
		end else if (roll < 60 && (ring.nfree != 0 || $urandom_range(0, 3) == 0)) begin
			op.func = vqdm_pkg::FUNC_ADD;
		end else begin
			op.func = vqdm_pkg::FUNC_COLLECT;
			if (n != 0 && $urandom_range(0, 9) != 0) begin
				op.used_id = ring.in_flight[$urandom_range(0, n - 1)] | hi;
				op.device_used_idx = ring.used_idx + 16'($urandom_range(1, n));
			end else if ($urandom_range(0, 1) != 0) begin
				op.device_used_idx = ring.used_idx;
			end
		end
		return op;
	endfunction

	// Present one operation and hold it until the transfer; return on the edge
	// that takes it, with valid still high so back-to-back items need no gap.
	task automatic push_op(input vqdm_pkg::in_item_t op);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= op;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	// Write the queue size only with the block drained.
	task automatic set_queue_size(input logic [vqdm_pkg::CFG_W-1:0] v);
		in_valid <= 1'b0;
		while (ring.due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(negedge clk); while (!cfg_ready);
		ring.write_size(v);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		vqdm_pkg::in_item_t op;
		logic [vqdm_pkg::CFG_W-1:0] sizes [12];
		sizes = '{9'd0, 9'd2, 9'd511, 9'd3, 9'd8, 9'd100, 9'd16, 9'd256, 9'd4, 9'd32,
			9'd64, 9'd1};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, full-size queue straight out of reset.
		set_idle(IDLE_NONE);
		op = '0;
		op.func = vqdm_pkg::FUNC_READ;
		push_op(op);                        // first entry: NEXT flag, links to 1
		op.read_index = 8'hff;
		push_op(op);                        // last entry: no flag, links to 0
		op = '0;
		op.func = vqdm_pkg::FUNC_COLLECT;
		push_op(op);                        // indices equal: nothing used yet
		op = '1;
		op.func = vqdm_pkg::FUNC_ADD;
		push_op(op);                        // all-ones operands
		op = '0;
		op.func = vqdm_pkg::FUNC_ADD;
		push_op(op);                        // all-zero operands
		op = '0;
		op.func = vqdm_pkg::FUNC_READ;
		push_op(op);
		op = '0;
		op.func = vqdm_pkg::FUNC_COLLECT;
		op.device_used_idx = 16'd1;
		op.used_len = '1;
		push_op(op);                        // returns the all-ones tag
		push_op(op);                        // same device index again: nothing used
		op = '0;
		op.func = vqdm_pkg::FUNC_READ;
		push_op(op);                        // freed entry now links to the old head
		op = '1;
		op.func = FUNC_NOP;
		push_op(op);
		op = '0;
		op.func = vqdm_pkg::FUNC_COLLECT;
		op.device_used_idx = 16'hffff;
		op.used_id = 8'd200;
		push_op(op);                        // never taken: free count saturates
		op.used_id = 8'd201;
		push_op(op);

		// Directed, single-descriptor queue: full, and ids wrapped to the size.
		set_queue_size(9'd1);
		op = '1;
		op.func = vqdm_pkg::FUNC_ADD;
		push_op(op);
		push_op(op);                        // no free descriptor
		op = '0;
		op.func = vqdm_pkg::FUNC_READ;
		op.read_index = 8'hff;
		push_op(op);
		op = '0;
		op.func = vqdm_pkg::FUNC_COLLECT;
		op.device_used_idx = 16'd1;
		op.used_id = 8'hff;
		push_op(op);
		op = '1;
		op.func = vqdm_pkg::FUNC_ADD;
		op.tag = '0;
		push_op(op);

		// Random phases, one queue size each; rotate the idle pattern.
		foreach (sizes[k]) begin
			set_queue_size(sizes[k]);
			set_idle(idle_mode_e'(k % 4));
			repeat (PHASE_OPS) push_op(make_op());
		end

		// Run add/collect pairs back to back on a two-entry queue.
		set_queue_size(9'd2);
		set_idle(IDLE_NONE);
		repeat (PAIR_OPS) begin
			op = make_op();
			op.func = vqdm_pkg::FUNC_ADD;
			push_op(op);
			op = make_op();
			op.func = vqdm_pkg::FUNC_COLLECT;
			op.device_used_idx = ring.used_idx + 16'd1;
			op.used_id = ring.in_flight[0];
			push_op(op);
		end

		// Keep going with the indices left as they are.
		set_idle(IDLE_BOTH);
		repeat (TAIL_OPS) push_op(make_op());

		in_valid <= 1'b0;
		while (ring.due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (ring.errors == 0 && ring.due_results.size() == 0) begin
			$display("virtqueue_descriptor_manager regression: pass");
		end else begin
			$display("virtqueue_descriptor_manager regression: fail");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/vqdm_pkg.sv
hdl/vqdm_ctrl.sv
hdl/vqdm_dp.sv
hdl/virtqueue_descriptor_manager.sv
hdl/vqdm_checker.sv
test/tb_virtqueue_descriptor_manager.sv
